// ----- rtl/rnt_pkg.sv -----
// shared types, constants and codes for the rssi neighbor table
package rnt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int ADDR_W      = 16;
  localparam int STR_W       = 8;

  // strength bounds
  localparam logic [STR_W-1:0] STRENGTH_FLOOR = 8'h81;  // -127
  localparam logic [STR_W-1:0] STRENGTH_CEIL  = 8'h7f;  // 127

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    OUT_REJECTED     = 3'd0,
    OUT_AVERAGED     = 3'd1,
    OUT_REMOVED      = 3'd2,
    OUT_INSERTED     = 3'd3,
    OUT_REPLACED     = 3'd4,
    OUT_IS_NEIGHBOR  = 3'd5,
    OUT_NOT_NEIGHBOR = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STR_W-1:0]  strength;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [3:0]        slot;
    logic [STR_W-1:0]  strength;
    logic [STR_W-1:0]  maximum;
  } result_t;

endpackage

// ----- rtl/rnt_entry_ram.sv -----
// slot address and strength memory, one write port and one registered read port
module rnt_entry_ram (
  input  logic                       clk,
  input  logic [rnt_pkg::SLOT_W-1:0] rd_idx,
  output rnt_pkg::entry_t            rd_data,
  input  rnt_pkg::ram_wr_t           wr
);
  import rnt_pkg::*;

  entry_t mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

endmodule

// ----- rtl/rnt_ctrl.sv -----
// scan sequencer, decision logic, valid bits and running maximum
module rnt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [rnt_pkg::ADDR_W-1:0] in_addr,
  input  logic [rnt_pkg::STR_W-1:0]  in_rssi,
  input  logic                       out_free,
  output logic                       res_load,
  output rnt_pkg::result_t           res,
  output logic [rnt_pkg::SLOT_W-1:0] rd_idx,
  input  rnt_pkg::entry_t            rd_data,
  output rnt_pkg::ram_wr_t           wr
);
  import rnt_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  state_t state, state_next;

  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [STR_W-1:0]       best;

  // captured item
  logic              op;
  logic [ADDR_W-1:0] addr;
  logic [STR_W-1:0]  rssi;

  logic [SLOT_W-1:0] scan_idx;
  logic              cmp_en;
  logic [SLOT_W-1:0] cmp_idx;

  // scan results
  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic [STR_W-1:0]  hit_str;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              min_found;
  logic [SLOT_W-1:0] min_idx;
  logic [STR_W-1:0]  min_str;

  logic              accept;
  logic              cmp_valid;

  // decision
  logic [9:0]        best2;
  logic [8:0]        sum;
  logic [8:0]        sum_adj;
  logic [STR_W-1:0]  avg;
  logic [STR_W-1:0]  best_next;
  logic              set_valid;
  logic              clr_valid;
  logic [SLOT_W-1:0] dec_idx;
  logic              dec_write;

  assign accept    = in_valid && in_ready;
  assign cmp_valid = slot_valid[cmp_idx];
  assign rd_idx    = scan_idx;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (scan_idx == LAST_SLOT) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_DECIDE;
      S_DECIDE: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    res_load = (state == S_DECIDE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture and scan counter
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= in_op;
      addr <= in_addr;
      rssi <= in_rssi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_en   <= 1'b0;
    end else begin
      cmp_en <= (state == S_SCAN);
      if (accept) begin
        scan_idx <= '0;
      end else if (state == S_SCAN && scan_idx != LAST_SLOT) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    cmp_idx <= scan_idx;
  end

  // compare stage on the read data, one slot per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      min_found  <= 1'b0;
      min_str    <= STRENGTH_CEIL;
    end else if (cmp_en) begin
      if (!hit_found && cmp_valid && rd_data.addr == addr) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_str   <= rd_data.strength;
      end
      if (!free_found && !cmp_valid) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (cmp_valid && $signed(rd_data.strength) < $signed(min_str)) begin
        min_found <= 1'b1;
        min_idx   <= cmp_idx;
        min_str   <= rd_data.strength;
      end
    end
  end

  // averaging truncates toward zero: bump a negative odd sum before the shift
  assign best2   = {best[STR_W-1], best, 1'b0};
  assign sum     = {hit_str[STR_W-1], hit_str} + {rssi[STR_W-1], rssi};
  assign sum_adj = sum + {8'd0, sum[8] & sum[0]};
  assign avg     = sum_adj[8:1];

  always_comb begin
    res.outcome  = OUT_REJECTED;
    res.slot     = '0;
    res.strength = '0;
    best_next    = best;
    set_valid    = 1'b0;
    clr_valid    = 1'b0;
    dec_idx      = hit_idx;
    dec_write    = 1'b0;
    wr.data.addr     = addr;
    wr.data.strength = rssi;
    if (op == OP_QUERY) begin
      if (hit_found) begin
        res.outcome  = OUT_IS_NEIGHBOR;
        res.slot     = 4'(hit_idx);
        res.strength = hit_str;
      end else begin
        res.outcome  = OUT_NOT_NEIGHBOR;
      end
    end else if (hit_found) begin
      dec_write        = 1'b1;
      wr.data.strength = avg;
      res.slot         = 4'(hit_idx);
      res.strength     = avg;
      if ($signed({{2{avg[STR_W-1]}}, avg}) < $signed(best2)) begin
        clr_valid   = 1'b1;
        res.outcome = OUT_REMOVED;
      end else begin
        res.outcome = OUT_AVERAGED;
        if ($signed(avg) > $signed(best)) best_next = avg;
      end
    end else if ($signed({{2{rssi[STR_W-1]}}, rssi}) >= $signed(best2)) begin
      if (free_found) begin
        dec_write    = 1'b1;
        set_valid    = 1'b1;
        dec_idx      = free_idx;
        res.outcome  = OUT_INSERTED;
        res.slot     = 4'(free_idx);
        res.strength = rssi;
        if ($signed(rssi) > $signed(best)) best_next = rssi;
      end else if (min_found && $signed(rssi) > $signed(min_str)) begin
        dec_write    = 1'b1;
        dec_idx      = min_idx;
        res.outcome  = OUT_REPLACED;
        res.slot     = 4'(min_idx);
        res.strength = rssi;
        if ($signed(rssi) > $signed(best)) best_next = rssi;
      end
    end
    res.maximum = best_next;
    wr.en       = dec_write && res_load;
    wr.idx      = dec_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      best       <= STRENGTH_FLOOR;
    end else if (res_load) begin
      best <= best_next;
      if (set_valid) slot_valid[dec_idx] <= 1'b1;
      if (clr_valid) slot_valid[dec_idx] <= 1'b0;
    end
  end

  // running maximum never falls
  a_best_rises: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $signed(best) >= $signed($past(best)))
    else $error("running maximum decreased");

  // memory is written only as a result is handed over
  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> res_load && state == S_DECIDE)
    else $error("memory write outside decision");

  // a replacement needs a full table
  a_replace_full: assert property (@(posedge clk) disable iff (rst)
    res_load && res.outcome == OUT_REPLACED |-> &slot_valid)
    else $error("replacement with a free slot");

  // an inserted slot is valid afterwards
  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    res_load && res.outcome == OUT_INSERTED |=> slot_valid[$past(wr.idx)])
    else $error("inserted slot not marked valid");

endmodule

// ----- rtl/rssi_neighbor_table.sv -----
// top level of the rssi neighbor table: stream ports, output register, core wiring
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  tuser: operation; tdata: address, rssi
//   m_*      out  m_tvalid / m_tready  tuser: outcome; tdata: slot, rssi, maximum
//
// an item is accepted in the idle state, then each slot is read in turn through
// the single read port, the last read lands in the drain state, and the decision
// state writes the entry back on an update that changes the table.
// the decision cycle holds while the output register is full and not taken.
// reset clears the valid bits and sets the maximum to -127; the memory itself
// is never cleared, an invalid slot is simply ignored.
module rssi_neighbor_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] node_address, [23:16] signal_strength
  input  logic [0:0]  s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] entry_slot, [11:4] entry_strength,
                                 // [19:12] strength_maximum, [23:20] zero
  output logic [2:0]  m_tuser    // [2:0] outcome
);
  import rnt_pkg::*;

  logic              out_full;
  logic              out_free;
  logic              res_load;
  result_t           res;
  result_t           out_res;
  logic [SLOT_W-1:0] rd_idx;
  entry_t            rd_data;
  ram_wr_t           wr;

  // output register can take a new beat when empty or being drained
  assign out_free = !out_full || m_tready;

  rnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser[0]),
    .in_addr  (s_tdata[15:0]),
    .in_rssi  (s_tdata[23:16]),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data),
    .wr       (wr)
  );

  rnt_entry_ram u_ram (
    .clk     (clk),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_load) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_full;
  assign m_tuser  = out_res.outcome;
  assign m_tdata  = {4'd0, out_res.maximum, out_res.strength, out_res.slot};

endmodule
